@@ rtl/abr_pkg.sv @@
package abr_pkg;

    localparam int ACTION_W = 2;
    localparam int RATE_W   = 24;
    localparam int BYTES_W  = 32;
    localparam int TIME_W   = 32;
    localparam int EST_W    = 32;
    localparam int WEIGHT_W = 17;

    localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SELECT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CHUNK  = 2'd2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 17'd65536;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd16384;

    // The sample is bytes * 2048 / elapsed, so the dividend carries 11 extra bits.
    localparam int SAMPLE_SHIFT = 11;
    localparam int DIVIDEND_W   = BYTES_W + SAMPLE_SHIFT;
    localparam int DIV_STEPS    = DIVIDEND_W;
    localparam int STEP_W       = 6;

    localparam int PROD_W = WEIGHT_W + EST_W;

endpackage

@@ rtl/abr_if.sv @@
interface abr_req_if;
    import abr_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [RATE_W-1:0]   bitrate_value;
    logic                list_start;
    logic                list_end;
    logic [BYTES_W-1:0]  chunk_bytes;
    logic [TIME_W-1:0]   elapsed_us;

    modport source (
        output valid, action, bitrate_value, list_start, list_end, chunk_bytes, elapsed_us,
        input  ready
    );

    modport sink (
        input  valid, action, bitrate_value, list_start, list_end, chunk_bytes, elapsed_us,
        output ready
    );
endinterface

interface abr_rsp_if;
    import abr_pkg::*;

    logic              valid;
    logic              ready;
    logic [RATE_W-1:0] chosen_bitrate;
    logic [EST_W-1:0]  throughput_estimate;
    logic              table_overflow;

    modport source (
        output valid, chosen_bitrate, throughput_estimate, table_overflow,
        input  ready
    );

    modport sink (
        input  valid, chosen_bitrate, throughput_estimate, table_overflow,
        output ready
    );
endinterface

interface abr_cfg_if;
    import abr_pkg::*;

    logic                valid;
    logic                ready;
    logic [WEIGHT_W-1:0] smoothing_weight;

    modport source (
        output valid, smoothing_weight,
        input  ready
    );

    modport sink (
        input  valid, smoothing_weight,
        output ready
    );
endinterface

@@ rtl/abr_bitrate_selector.sv @@
// Channel    Modport  Payload
// request    sink     action, bitrate_value, list_start, list_end, chunk_bytes, elapsed_us
// response   source   chosen_bitrate, throughput_estimate, table_overflow
// cfg        sink     smoothing_weight
//
// One request is worked on at a time by a small sequencer around one table port,
// one restoring divider step and one 17 x 32 multiplier.
// An add steps through the entries it compares (none when full), and list_end adds a table read.
// A select steps through the entries it visits; a chunk runs the divider (skipped if elapsed is 0) and the multiplier.
// Reset clears the count and the estimate; the table memory is not cleared.
// A finished result waits in the response register while the next request is taken.
module abr_bitrate_selector #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    abr_req_if.sink   request,
    abr_rsp_if.source response,
    abr_cfg_if.sink   cfg
);
    import abr_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0000000000001,
        S_INS_RD  = 13'b0000000000010,
        S_INS_CMP = 13'b0000000000100,
        S_INS_WR  = 13'b0000000001000,
        S_END_RD  = 13'b0000000010000,
        S_END_LD  = 13'b0000000100000,
        S_SEL_RD  = 13'b0000001000000,
        S_SEL_CMP = 13'b0000010000000,
        S_DIV     = 13'b0000100000000,
        S_MUL_A   = 13'b0001000000000,
        S_MUL_B   = 13'b0010000000000,
        S_MUL_SUM = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [RATE_W-1:0] table_mem [TABLE_DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [RATE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [RATE_W-1:0] rd_data_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      pos_reg;
    logic [CNT_W-1:0]      k_reg;
    logic [EST_W-1:0]      est_reg;
    logic [WEIGHT_W-1:0]   weight_reg;
    logic [RATE_W-1:0]     value_reg;
    logic                  end_reg;
    logic [TIME_W-1:0]     us_reg;
    logic [RATE_W-1:0]     chosen_reg;
    logic                  ovf_reg;
    logic [DIVIDEND_W-1:0] div_reg;
    logic [TIME_W-1:0]     rem_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [PROD_W-1:0]     acc_reg;

    logic              rsp_valid_reg;
    logic [RATE_W-1:0] rsp_chosen_reg;
    logic [EST_W-1:0]  rsp_est_reg;
    logic              rsp_ovf_reg;

    logic                accept;
    logic                rsp_load;
    logic [CNT_W-1:0]    cnt_base;
    logic [CNT_W-1:0]    pos_m1;
    logic [CNT_W-1:0]    k_p1;
    logic [RATE_W+8:0]   need;
    logic                pass;
    logic [TIME_W:0]     rem_sh;
    logic                div_ge;
    logic [WEIGHT_W-1:0] a_eff;
    logic [WEIGHT_W-1:0] a_rest;
    logic [EST_W-1:0]    sample;
    logic [WEIGHT_W-1:0] mul_a;
    logic [EST_W-1:0]    mul_b;
    logic [PROD_W-1:0]   mul_p;
    logic [PROD_W-1:0]   sum;

    assign request.ready = (state_reg == S_IDLE);
    assign accept        = request.valid && request.ready;
    assign cfg.ready     = 1'b1;

    assign response.valid               = rsp_valid_reg;
    assign response.chosen_bitrate      = rsp_chosen_reg;
    assign response.throughput_estimate = rsp_est_reg;
    assign response.table_overflow      = rsp_ovf_reg;

    assign rsp_load = (state_reg == S_DONE) && (!rsp_valid_reg || response.ready);

    assign cnt_base = request.list_start ? '0 : count_reg;
    assign pos_m1   = pos_reg - 1'b1;
    assign k_p1     = k_reg + 1'b1;

    // The selection margin of 1.5 is compared exactly as estimate >= entry * 384.
    assign need = {1'b0, rd_data_reg, 8'b0} + {2'b0, rd_data_reg, 7'b0};
    assign pass = {1'b0, est_reg} >= need;

    assign rem_sh = {rem_reg, div_reg[DIVIDEND_W-1]};
    assign div_ge = rem_sh >= {1'b0, us_reg};

    assign a_eff  = weight_reg[WEIGHT_W-1] ? WEIGHT_ONE : weight_reg;
    assign a_rest = WEIGHT_ONE - a_eff;
    assign sample = (|div_reg[DIVIDEND_W-1:EST_W]) ? '1 : div_reg[EST_W-1:0];

    assign mul_a = (state_reg == S_MUL_A) ? a_rest : a_eff;
    assign mul_b = (state_reg == S_MUL_A) ? est_reg : sample;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign sum   = acc_reg + prod_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg[ADDR_W-1:0];
        mem_wdata = value_reg;
        mem_raddr = '0;
        case (state_reg)
            S_INS_RD:
            begin
                mem_raddr = pos_m1[ADDR_W-1:0];
            end
            S_INS_CMP:
            begin
                mem_we    = rd_data_reg > value_reg;
                mem_wdata = rd_data_reg;
            end
            S_INS_WR:
            begin
                mem_we = 1'b1;
            end
            S_SEL_RD:
            begin
                mem_raddr = k_reg[ADDR_W-1:0];
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= table_mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.action)
                        ACT_ADD:
                        begin
                            if (cnt_base >= CNT_W'(TABLE_DEPTH))
                            begin
                                state_next = request.list_end ? S_END_RD : S_DONE;
                            end
                            else if (cnt_base == '0)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                state_next = S_INS_RD;
                            end
                        end
                        ACT_SELECT:
                        begin
                            state_next = (count_reg == '0) ? S_DONE : S_SEL_RD;
                        end
                        ACT_CHUNK:
                        begin
                            state_next = (request.elapsed_us == '0) ? S_MUL_A : S_DIV;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_INS_RD:
            begin
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (rd_data_reg > value_reg && pos_m1 != '0)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                state_next = end_reg ? S_END_RD : S_DONE;
            end
            S_END_RD:
            begin
                state_next = S_END_LD;
            end
            S_END_LD:
            begin
                state_next = S_DONE;
            end
            S_SEL_RD:
            begin
                state_next = S_SEL_CMP;
            end
            S_SEL_CMP:
            begin
                state_next = (pass && k_p1 != count_reg) ? S_SEL_RD : S_DONE;
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                state_next = S_MUL_SUM;
            end
            S_MUL_SUM:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            est_reg       <= '0;
            weight_reg    <= WEIGHT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                weight_reg <= cfg.smoothing_weight;
            end
            if (accept && request.action == ACT_ADD)
            begin
                count_reg <= cnt_base;
            end
            if (state_reg == S_INS_WR)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_END_LD)
            begin
                est_reg <= {rd_data_reg, 8'b0};
            end
            if (state_reg == S_MUL_SUM)
            begin
                est_reg <= sum[EST_W+15:16];
            end
            if (response.valid && response.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_reg  <= request.bitrate_value;
            end_reg    <= request.list_end;
            us_reg     <= request.elapsed_us;
            pos_reg    <= cnt_base;
            k_reg      <= '0;
            chosen_reg <= '0;
            ovf_reg    <= (request.action == ACT_ADD) && (cnt_base >= CNT_W'(TABLE_DEPTH));
            rem_reg    <= '0;
            step_reg   <= '0;
            if (request.elapsed_us == '0)
            begin
                div_reg <= '1;
            end
            else
            begin
                div_reg <= {request.chunk_bytes, {SAMPLE_SHIFT{1'b0}}};
            end
        end
        if (state_reg == S_INS_CMP && rd_data_reg > value_reg)
        begin
            pos_reg <= pos_m1;
        end
        if (state_reg == S_SEL_CMP)
        begin
            if (k_reg == '0 || pass)
            begin
                chosen_reg <= rd_data_reg;
            end
            k_reg <= k_p1;
        end
        if (state_reg == S_DIV)
        begin
            if (div_ge)
            begin
                rem_reg <= TIME_W'(rem_sh - {1'b0, us_reg});
            end
            else
            begin
                rem_reg <= rem_sh[TIME_W-1:0];
            end
            div_reg  <= {div_reg[DIVIDEND_W-2:0], div_ge};
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == S_MUL_A)
        begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_MUL_B)
        begin
            acc_reg  <= prod_reg;
            prod_reg <= mul_p;
        end
        if (rsp_load)
        begin
            rsp_chosen_reg <= chosen_reg;
            rsp_est_reg    <= est_reg;
            rsp_ovf_reg    <= ovf_reg;
        end
    end

endmodule
